FILE: rtl/core/pli_pkg.sv
// -----------------------------------------------------------------------------
// pli_pkg
// Shared constants and types for the profile linear interpolator.
// -----------------------------------------------------------------------------
package pli_pkg;

    // Table depth and the address width that follows from it.
    localparam int MAX_POINTS = 32;
    localparam int AW         = $clog2(MAX_POINTS);

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_TIME  = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd1;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd2;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result regions.
    localparam logic [1:0] REGION_BEFORE = 2'd0;
    localparam logic [1:0] REGION_INTERP = 2'd1;
    localparam logic [1:0] REGION_AFTER  = 2'd2;
    localparam logic [1:0] REGION_SHORT  = 2'd3;

    // One table entry: a time and three angles (pitch, yaw, roll).
    typedef struct packed {
        logic signed [31:0]        t;
        logic [2:0][31:0]          ang;
    } t_point;

    // Divider control between the sequencer and the division unit.
    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } t_div_rsp;

endpackage

FILE: rtl/core/pli_if.sv
// -----------------------------------------------------------------------------
// pli_if
// Handshake channels of the profile linear interpolator.
// -----------------------------------------------------------------------------
interface pli_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [4:0]         point_index;
    logic signed [31:0] sample_time;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
    logic signed [31:0] roll_in;
    modport source (output valid, kind, point_index, sample_time, pitch_in, yaw_in,
                    roll_in, input ready);
    modport sink   (input valid, kind, point_index, sample_time, pitch_in, yaw_in,
                    roll_in, output ready);
endinterface

interface pli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_out;
    logic signed [31:0] yaw_out;
    logic signed [31:0] roll_out;
    logic [1:0]         region;
    modport source (output valid, pitch_out, yaw_out, roll_out, region, input ready);
    modport sink   (input valid, pitch_out, yaw_out, roll_out, region, output ready);
endinterface

interface pli_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pli_div.sv
// -----------------------------------------------------------------------------
// pli_div
// Restoring divider giving sixteen fraction bits of num / den, one per cycle.
// The caller guarantees num < den, so the quotient is below one.
// -----------------------------------------------------------------------------
module pli_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pli_pkg::t_div_req i_req,
    output pli_pkg::t_div_rsp o_rsp
);

    logic [33:0] r_rem;
    logic [33:0] n_rem;
    logic [33:0] w_shift;
    logic [15:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        w_bit;

    // One trial subtraction per cycle.
    assign w_shift = {r_rem[32:0], 1'b0};
    assign w_bit   = (w_shift >= {1'b0, i_req.den});
    assign n_rem   = w_bit ? (w_shift - {1'b0, i_req.den}) : w_shift;

    // Sixteen steps, then one cycle with the finished quotient flagged as done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
            r_rem  <= {1'b0, i_req.num};
            r_quot <= 16'd0;
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[14:0], w_bit};
                r_cnt  <= r_cnt - 5'd1;
            end
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == 5'd0);
    assign o_rsp.quot = r_quot;

endmodule

FILE: rtl/core/profile_linear_interpolator.sv
// -----------------------------------------------------------------------------
// profile_linear_interpolator
// Piecewise linear lookup of three angles in a table of timed points.
// -----------------------------------------------------------------------------
// A load item writes one table point and gives no result.
// A query item makes two table reads to test the ends, one read per point
// walked by the linear segment search (one read port, so up to MAX_POINTS - 1
// reads), the bit-serial divider for the fraction (sixteen steps and a done
// cycle) when it is below one, then one multiply and one add per angle
// in the shared multiplier. The input is not ready while a query is in
// progress; a finished result sits in an output register, so the next item
// may be taken while it waits.
module profile_linear_interpolator (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pli_in_if.sink   i_in,
    pli_cfg_if.sink  i_cfg,
    pli_out_if.source o_res
);

    localparam int AW = pli_pkg::AW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK0 = 4'd1;
    localparam logic [3:0] S_CHKN = 4'd2;
    localparam logic [3:0] S_SRCH = 4'd3;
    localparam logic [3:0] S_DT   = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // Configuration registers.
    logic signed [31:0] r_start;
    logic [30:0]        r_tol;
    logic [5:0]         r_count;

    // Point table and its registered read port.
    pli_pkg::t_point    mem [pli_pkg::MAX_POINTS];
    pli_pkg::t_point    r_rd;
    logic [AW-1:0]      w_addr;

    logic [3:0]         r_state;
    logic signed [31:0] r_elapsed;
    logic [AW-1:0]      r_last;
    logic [AW-1:0]      r_j;
    pli_pkg::t_point    r_lo;
    pli_pkg::t_point    r_hi;
    logic [15:0]        r_alpha;
    logic [1:0]         r_a;
    logic signed [49:0] r_prod;
    logic [2:0][31:0]   r_res;
    logic [1:0]         r_region;

    logic               r_ovalid;
    logic [2:0][31:0]   r_oang;
    logic [1:0]         r_oreg;

    logic               w_acc;
    logic signed [32:0] w_diff;
    logic signed [31:0] w_elapsed;
    logic [AW-1:0]      w_last;
    logic signed [32:0] w_dt;
    logic signed [32:0] w_num;
    logic signed [32:0] w_adiff;
    logic               w_emit;

    pli_pkg::t_div_req  w_dreq;
    pli_pkg::t_div_rsp  w_drsp;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_acc       = i_in.valid && (r_state == S_IDLE);
    assign w_emit      = (r_state == S_DONE) && (!r_ovalid || o_res.ready);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 32'sd0;
            r_tol   <= 31'd1;
            r_count <= 6'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pli_pkg::CFG_START_TIME:  r_start <= i_cfg.data;
                pli_pkg::CFG_TOLERANCE:   r_tol   <= i_cfg.data[30:0];
                pli_pkg::CFG_POINT_COUNT: r_count <= i_cfg.data[5:0];
                default: ;
            endcase
        end
    end

    // Saturating elapsed time and the index of the last valid point.
    assign w_diff    = 33'(i_in.sample_time) - 33'(r_start);
    assign w_elapsed = (w_diff[32] != w_diff[31]) ?
                       (w_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_diff[31:0];
    always_comb begin
        if (r_count == 6'd0) begin
            w_last = '0;
        end else if (32'(r_count) > pli_pkg::MAX_POINTS) begin
            w_last = AW'(pli_pkg::MAX_POINTS - 1);
        end else begin
            w_last = AW'(r_count - 6'd1);
        end
    end

    // Read address for the next table access. During the search the entry
    // in r_rd is r_j + 1, so the one after it is fetched ahead.
    always_comb begin
        unique case (r_state)
            S_CHK0:  w_addr = r_last;
            S_CHKN:  w_addr = AW'(1);
            S_SRCH:  w_addr = r_j + AW'(2);
            default: w_addr = '0;
        endcase
    end

    // Table write on a load item, registered read every cycle.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.kind == pli_pkg::KIND_LOAD &&
            32'(i_in.point_index) < pli_pkg::MAX_POINTS) begin
            mem[AW'(i_in.point_index)] <= {i_in.sample_time, i_in.roll_in,
                                           i_in.yaw_in, i_in.pitch_in};
        end
        r_rd <= mem[w_addr];
    end

    // Segment length, offset into it and angle difference for the multiplier.
    assign w_dt    = 33'(r_hi.t) - 33'(r_lo.t);
    assign w_num   = 33'(r_elapsed) - 33'(r_lo.t);
    assign w_adiff = 33'($signed(r_hi.ang[r_a])) - 33'($signed(r_lo.ang[r_a]));

    assign w_dreq.start = (r_state == S_DT) && !(w_dt < 33'(r_tol)) && (w_num < w_dt);
    assign w_dreq.num   = w_num;
    assign w_dreq.den   = w_dt;

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // Query sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_in.kind == pli_pkg::KIND_QUERY) begin
                        r_elapsed <= w_elapsed;
                        r_last    <= w_last;
                        r_state   <= S_CHK0;
                    end
                end
                S_CHK0: begin
                    r_lo <= r_rd;
                    if (r_elapsed <= r_rd.t || r_last == '0) begin
                        r_res    <= r_rd.ang;
                        r_region <= (r_elapsed <= r_rd.t) ? pli_pkg::REGION_BEFORE
                                                          : pli_pkg::REGION_AFTER;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_CHKN;
                    end
                end
                S_CHKN: begin
                    if (r_elapsed >= r_rd.t) begin
                        r_res    <= r_rd.ang;
                        r_region <= pli_pkg::REGION_AFTER;
                        r_state  <= S_DONE;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_rd.t < r_elapsed) begin
                        r_lo <= r_rd;
                        r_j  <= r_j + AW'(1);
                    end else begin
                        r_hi    <= r_rd;
                        r_state <= S_DT;
                    end
                end
                S_DT: begin
                    r_a <= 2'd0;
                    if (w_dt < 33'(r_tol)) begin
                        r_res    <= r_lo.ang;
                        r_region <= pli_pkg::REGION_SHORT;
                        r_state  <= S_DONE;
                    end else if (w_num < w_dt) begin
                        r_state <= S_DIV;
                    end else begin
                        r_alpha <= 16'hFFFF;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_alpha <= w_drsp.quot;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 50'(w_adiff) * 50'($signed({1'b0, r_alpha}));
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_res[r_a] <= r_lo.ang[r_a] + r_prod[47:16];
                    if (r_a == 2'd2) begin
                        r_region <= pli_pkg::REGION_INTERP;
                        r_state  <= S_DONE;
                    end else begin
                        r_a     <= r_a + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oang <= r_res;
            r_oreg <= r_region;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.pitch_out = r_oang[0];
    assign o_res.yaw_out   = r_oang[1];
    assign o_res.roll_out  = r_oang[2];
    assign o_res.region    = r_oreg;

endmodule

FILE: dv/pli_tb_if.sv
// -----------------------------------------------------------------------------
// pli_tb_if
// Notes on the channel interfaces used by the interpolator testbench.
// -----------------------------------------------------------------------------
// The handshake channels themselves (pli_in_if, pli_cfg_if, pli_out_if) come
// from the design's own interface file. This file holds a small helper
// interface that carries the checker's status back to the testbench top.
interface pli_status_if;
    int unsigned errors;
    int unsigned pending;
    int unsigned queries;
    int unsigned interp_seen;
    modport source (output errors, pending, queries, interp_seen);
    modport sink   (input errors, pending, queries, interp_seen);
endinterface

FILE: dv/pli_checker.sv
// -----------------------------------------------------------------------------
// pli_checker
// Watches the interpolator channels, predicts each query and compares.
// -----------------------------------------------------------------------------
module pli_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pli_in_if             i_in,
    pli_cfg_if            i_cfg,
    pli_out_if            i_res,
    pli_status_if.source  o_stat
);
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
        logic signed [31:0] roll;
        logic [1:0]         region;
    } t_angles;

    // Shadow copy of the table and the registers.
    logic signed [31:0] tbl_time  [MAX_POINTS];
    logic signed [31:0] tbl_pitch [MAX_POINTS];
    logic signed [31:0] tbl_yaw   [MAX_POINTS];
    logic signed [31:0] tbl_roll  [MAX_POINTS];
    logic signed [31:0] start_time;
    logic [30:0]        tolerance;
    logic [5:0]         point_count;

    t_angles     angles_due[$];
    int unsigned errors;
    int unsigned queries;
    int unsigned interp_seen;

    assign o_stat.errors      = errors;
    assign o_stat.pending     = angles_due.size();
    assign o_stat.queries     = queries;
    assign o_stat.interp_seen = interp_seen;

    // One angle moved along a segment by a Q0.16 fraction, rounding down.
    function automatic logic signed [31:0] blend(input logic signed [31:0] a0,
                                                 input logic signed [31:0] a1,
                                                 input logic [15:0] frac);
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        diff = 64'(a1) - 64'(a0);
        prod = diff * $signed({48'd0, frac});
        return 32'(64'(a0) + (prod >>> 16));
    endfunction

    // Expected angles for a query at time qt.
    function automatic t_angles look_up(input logic signed [31:0] qt);
        t_angles            r;
        logic signed [63:0] e;
        logic signed [31:0] el;
        logic signed [63:0] dt;
        logic [63:0]        quo;
        int                 n;
        int                 i;
        e = 64'(qt) - 64'(start_time);
        if (e > 64'sd2147483647) e = 64'sd2147483647;
        if (e < -64'sd2147483648) e = -64'sd2147483648;
        el = 32'(e);
        n = (point_count == 0) ? 1 : (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
        if (el <= tbl_time[0]) begin
            r = '{tbl_pitch[0], tbl_yaw[0], tbl_roll[0], REGION_BEFORE};
            return r;
        end
        if (el >= tbl_time[n-1]) begin
            r = '{tbl_pitch[n-1], tbl_yaw[n-1], tbl_roll[n-1], REGION_AFTER};
            return r;
        end
        i = 0;
        while (i < n - 1 && tbl_time[i+1] < el) i++;
        if (i >= n - 1) i = n - 2;
        dt = 64'(tbl_time[i+1]) - 64'(tbl_time[i]);
        if (dt <= 0 || dt < 64'(tolerance)) begin
            r = '{tbl_pitch[i], tbl_yaw[i], tbl_roll[i], REGION_SHORT};
            return r;
        end
        e = 64'(el) - 64'(tbl_time[i]);
        if (e < 0) e = 0;
        quo = (64'(e) << 16) / 64'(dt);
        if (quo > 64'hFFFF) quo = 64'hFFFF;
        r.pitch  = blend(tbl_pitch[i], tbl_pitch[i+1], quo[15:0]);
        r.yaw    = blend(tbl_yaw[i],   tbl_yaw[i+1],   quo[15:0]);
        r.roll   = blend(tbl_roll[i],  tbl_roll[i+1],  quo[15:0]);
        r.region = REGION_INTERP;
        return r;
    endfunction

    // Follow every accepted item and result.
    always @(posedge i_clk) begin
        t_angles exp_a;
        if (!i_rst_n) begin
            start_time  <= '0;
            tolerance   <= 31'd1;
            point_count <= 6'd1;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_START_TIME:  start_time  <= i_cfg.data;
                    CFG_TOLERANCE:   tolerance   <= i_cfg.data[30:0];
                    CFG_POINT_COUNT: point_count <= i_cfg.data[5:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == KIND_LOAD) begin
                    tbl_time[i_in.point_index]  = i_in.sample_time;
                    tbl_pitch[i_in.point_index] = i_in.pitch_in;
                    tbl_yaw[i_in.point_index]   = i_in.yaw_in;
                    tbl_roll[i_in.point_index]  = i_in.roll_in;
                end else begin
                    angles_due.push_back(look_up(i_in.sample_time));
                    queries++;
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (angles_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result region=%0d", $time, i_res.region);
                end else begin
                    exp_a = angles_due.pop_front();
                    if (exp_a.region == REGION_INTERP) interp_seen++;
                    if (exp_a.pitch !== i_res.pitch_out || exp_a.yaw !== i_res.yaw_out ||
                        exp_a.roll !== i_res.roll_out || exp_a.region !== i_res.region) begin
                        errors++;
                        $display("%0t: mismatch expected p=%h y=%h r=%h reg=%0d",
                                 $time, exp_a.pitch, exp_a.yaw, exp_a.roll, exp_a.region);
                        $display("%0t:          actual   p=%h y=%h r=%h reg=%0d",
                                 $time, i_res.pitch_out, i_res.yaw_out, i_res.roll_out,
                                 i_res.region);
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_profile_linear_interpolator.sv
// -----------------------------------------------------------------------------
// tb_profile_linear_interpolator
// Stimulus and verdict for the profile linear interpolator.
// -----------------------------------------------------------------------------
// Loads sorted profiles with random angles, queries inside, around and beyond
// them under several register settings, with random gaps and output stalls;
// a checker beside the block predicts and compares every result.
module tb_profile_linear_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic stall_on;

    pli_in_if     in_ch ();
    pli_cfg_if    cfg_ch ();
    pli_out_if    res_ch ();
    pli_status_if stat ();

    logic signed [31:0] prof_time [MAX_POINTS];
    int                 prof_n;
    logic signed [31:0] cur_start;

    profile_linear_interpolator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    pli_checker u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .i_res   (res_ch),
        .o_stat  (stat)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls at random when enabled.
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n || !stall_on) begin
            res_ch.ready <= 1'b1;
        end else begin
            g = gap_len();
            res_ch.ready <= (g == 0) || ($urandom_range(0, 2) == 0);
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Drop the input valid and wait on the clock.
    task automatic hold_in();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one item and wait for it to be taken. Valid stays high afterwards
    // until the next item replaces it or the sender goes idle.
    task automatic send_item(input logic kind, input logic [4:0] idx,
                             input logic signed [31:0] t, input logic signed [31:0] p,
                             input logic signed [31:0] y, input logic signed [31:0] r);
        int g;
        g = stall_on ? gap_len() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            idle_cycles(g);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= kind;
        in_ch.point_index <= idx;
        in_ch.sample_time <= t;
        in_ch.pitch_in    <= p;
        in_ch.yaw_in      <= y;
        in_ch.roll_in     <= r;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic query_at(input logic signed [31:0] t);
        send_item(KIND_QUERY, 5'($urandom), t, $urandom, $urandom, $urandom);
    endtask

    // Let the input go idle and wait until every result has come back.
    task automatic drain();
        hold_in();
        while (stat.pending != 0) @(posedge i_clk);
        idle_cycles(80);
    endtask

    // Registers are written only with nothing in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // Load a profile of n points with nondecreasing times from base.
    task automatic load_profile(input int n, input logic signed [31:0] base,
                                input int unsigned max_step);
        logic signed [63:0] t;
        int                 k;
        t = base;
        for (k = 0; k < n; k++) begin
            if (k > 0) begin
                t = t + ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, max_step));
                if (t > 64'sd2147483647) t = 64'sd2147483647;
            end
            prof_time[k] = 32'(t);
            send_item(KIND_LOAD, 5'(k), 32'(t), rand_angle(), rand_angle(), rand_angle());
        end
        prof_n = n;
    endtask

    // Query time mostly relative to the loaded profile, with the start offset added; now and then fully random.
    function automatic logic signed [31:0] pick_time();
        logic signed [63:0] t;
        int                 k;
        k = $urandom_range(0, prof_n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: t = 64'(prof_time[k]);
            2: t = 64'(prof_time[0]) - $urandom_range(0, 1000);
            3: t = 64'(prof_time[prof_n-1]) + $urandom_range(0, 1000);
            default: t = 64'(prof_time[k]) + $urandom_range(0, 32'h0004_0000);
        endcase
        t = t + 64'(cur_start);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return 32'(t);
    endfunction

    int unsigned sent;
    int          ph;
    int          j;
    logic [30:0] tol;

    initial begin
        i_rst_n           = 1'b0;
        stall_on          = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_LOAD;
        in_ch.point_index = '0;
        in_ch.sample_time = '0;
        in_ch.pitch_in    = '0;
        in_ch.yaw_in      = '0;
        in_ch.roll_in     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_START_TIME;
        cfg_ch.data       = '0;
        cur_start         = '0;
        sent              = 0;
        idle_cycles(10);
        i_rst_n <= 1'b1;
        idle_cycles(2);

        // Directed: extreme angles, end regions, exact points, saturation.
        prof_time[0] = 32'sh8000_0000;
        send_item(KIND_LOAD, 5'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        query_at(32'sh8000_0000);
        query_at(32'sh7FFF_FFFF);
        send_item(KIND_LOAD, 5'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, -1);
        send_item(KIND_LOAD, 5'd2, 32'sh7FFF_FFFF, 1, 2, 3);
        send_item(KIND_LOAD, 5'd31, 32'sh7FFF_FFFF, 5, 6, 7);
        drain();
        write_reg(CFG_POINT_COUNT, 32'd2);
        query_at(0);
        query_at(32'sh7FFF_FFFE);
        query_at(32'sh8000_0001);
        write_reg(CFG_POINT_COUNT, 32'd0);
        drain();
        query_at(5);
        write_reg(CFG_POINT_COUNT, 32'd63);
        drain();
        load_profile(MAX_POINTS, 32'sh8000_0000, 32'h0800_0000);
        query_at(32'sh7FFF_FFFF);
        query_at(0);
        drain();
        write_reg(CFG_START_TIME, 32'h7FFF_FFFF);
        cur_start = 32'sh7FFF_FFFF;
        query_at(32'sh8000_0000);
        query_at(32'sh7FFF_FFFF);
        drain();
        write_reg(CFG_START_TIME, 32'h8000_0000);
        write_reg(CFG_TOLERANCE, 32'h7FFF_FFFF);
        cur_start = 32'sh8000_0000;
        query_at(32'sh7FFF_FFFF);
        query_at(-1);
        drain();
        sent = 48;

        // Random phases, each with its own registers and profile.
        stall_on = 1'b1;
        ph = 0;
        while (sent < 750) begin
            drain();
            case (ph % 4)
                0: tol = 31'd0;
                1: tol = 31'd1;
                2: tol = 31'($urandom_range(0, 32'h0002_0000));
                default: tol = 31'h7FFF_FFFF;
            endcase
            cur_start = (ph % 3 == 0) ? 32'sd0 : $signed($urandom_range(0, 32'h00FF_FFFF))
                        - 32'sh0080_0000;
            write_reg(CFG_START_TIME, cur_start);
            write_reg(CFG_TOLERANCE, {1'b0, tol});
            prof_n = (ph % 5 == 0) ? MAX_POINTS : $urandom_range(1, 8);
            write_reg(CFG_POINT_COUNT, 32'(prof_n));
            load_profile(prof_n, $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000,
                         (ph % 2) ? 32'h0001_0000 : 32'h0010_0000);
            sent += prof_n;
            for (j = 0; j < 40; j++) begin
                query_at(pick_time());
                sent++;
            end
            // Reload one slot with new angles but the same time, mid phase.
            if (prof_n > 1) begin
                j = $urandom_range(0, prof_n - 1);
                send_item(KIND_LOAD, 5'(j), prof_time[j], rand_angle(), rand_angle(),
                          rand_angle());
                sent++;
                query_at(pick_time());
                sent++;
            end
            // In one phase of three, hold the sender until every result is back.
            if (ph % 3 == 1) begin
                hold_in();
                while (stat.pending != 0) @(posedge i_clk);
            end
            ph++;
        end

        drain();
        $display("Covered %0d items in %0d profile phases: %0d queries, %0d interpolated.",
                 sent, ph, stat.queries, stat.interp_seen);
        if (stat.errors == 0) begin
            $display("[profile_linear_interpolator] OK");
        end else begin
            $display("[profile_linear_interpolator] ERROR");
        end
        $finish;
    end

    // Run limit far above the slowest correct run.
    initial begin
        #20ms;
        $display("[profile_linear_interpolator] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pli_pkg.sv
rtl/core/pli_if.sv
rtl/core/pli_div.sv
rtl/core/profile_linear_interpolator.sv
dv/pli_tb_if.sv
dv/pli_checker.sv
dv/tb_profile_linear_interpolator.sv
